@@ hdl/gte_pkg.sv @@
// Shared constants, tables and types for the geodetic to local ENU converter.
`default_nettype none
package gte_pkg;

  localparam int ANGLE_FRAC_BITS = 23;
  localparam int POS_FRAC_BITS   = 8;

  localparam int Q_BITS    = 30;
  localparam int ROT_STEPS = 30;

  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
  localparam logic signed [31:0] E2_Q30    = 32'sd7188036;
  localparam logic signed [32:0] ONE_Q30   = 33'sd1073741824;
  localparam logic signed [32:0] THREE_Q30 = 33'sd3221225472;
  localparam logic [22:0]        SEMI_MAJOR_M = 23'd6378137;

  // floor(x/45) = (x * MUL) >> SHIFT, exact over the ranges used
  localparam logic [31:0] DIV45_MUL      = 32'd3054198967;
  localparam int          DIV45_SHIFT    = 37;
  localparam logic [18:0] DIV45_MUL_LO   = 19'd372828;
  localparam int          DIV45_SHIFT_LO = 24;

  // input register of the ECEF unit to its outputs
  localparam int ECEF_LAT = 74;

  localparam logic [1:0] REG_REF_LAT = 2'd0;
  localparam logic [1:0] REG_REF_LON = 2'd1;
  localparam logic [1:0] REG_REF_ALT = 2'd2;
  localparam logic [1:0] REG_REF_SET = 2'd3;

  typedef struct packed {
    logic signed [31:0] sin_lat;
    logic signed [31:0] cos_lat;
    logic signed [31:0] sin_lon;
    logic signed [31:0] cos_lon;
  } trig_t;

  // arctan(2^-i) in binary-angle units
  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/gte_delay.sv @@
// Fixed-length shift line for aligning payload with the pipeline.
`default_nettype none
module gte_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < D; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[D-1];

endmodule
`default_nettype wire

@@ hdl/gte_mulq.sv @@
// Three-stage signed multiplier, product shifted right by 30 and truncated toward zero.
`default_nettype none
module gte_mulq #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int OW = 32
) (
  input  wire logic                 clk,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed      [OW-1:0] p
);

  localparam int MW = AW + BW - gte_pkg::Q_BITS;

  logic [AW-1:0]     ua;
  logic [BW-1:0]     ub;
  logic              neg1;
  logic [AW+BW-1:0]  prod;
  logic [MW-1:0]     mag;
  logic              neg2;
  logic signed [MW:0] smag;

  always_ff @(posedge clk) begin
    ua   <= a[AW-1] ? AW'(-a) : AW'(a);
    ub   <= b[BW-1] ? BW'(-b) : BW'(b);
    neg1 <= a[AW-1] ^ b[BW-1];
  end

  assign prod = (AW+BW)'(ua) * (AW+BW)'(ub);

  always_ff @(posedge clk) begin
    mag  <= prod[AW+BW-1:gte_pkg::Q_BITS];
    neg2 <= neg1;
  end

  assign smag = signed'({1'b0, mag});

  always_ff @(posedge clk) begin
    p <= neg2 ? OW'(-smag) : OW'(smag);
  end

endmodule
`default_nettype wire

@@ hdl/gte_sincos.sv @@
// Angle to binary angle conversion and 30-stage pipelined CORDIC sine/cosine in Q30.
`default_nettype none
module gte_sincos #(
  parameter int ANGLE_FRAC_BITS = gte_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic signed [31:0] angle,
  output logic signed      [31:0] sin_q,
  output logic signed      [31:0] cos_q
);

  localparam int SH   = 32 - ANGLE_FRAC_BITS;
  localparam int T    = SH - 3;
  localparam int RW   = 6 + T;
  localparam int P2W  = RW + 19;
  localparam int ROT  = gte_pkg::ROT_STEPS;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic [31:0]     mag1, mag2;
  logic            neg1, neg2, neg3, neg4, neg5;
  logic [63:0]     prod1;
  logic [26:0]     qa_c, qa3, qa4;
  logic [31:0]     rem_c;
  logic [5:0]      ra3;
  logic [P2W-1:0]  prod2;
  logic [31:0]     q5, bam6, bias, zr;
  logic [1:0]      quad7;
  logic signed [32:0] z7;

  logic signed [33:0] cx [1:ROT];
  logic signed [33:0] cy [1:ROT];
  logic signed [32:0] cz [1:ROT];
  logic [1:0]         cq [1:ROT];

  always_ff @(posedge clk) begin
    mag1 <= angle[31] ? 32'(-angle) : 32'(angle);
    neg1 <= angle[31];
    prod1 <= 64'(mag1) * 64'(gte_pkg::DIV45_MUL);
    mag2  <= mag1;
    neg2  <= neg1;
  end

  assign qa_c  = prod1[gte_pkg::DIV45_SHIFT +: 27];
  assign rem_c = mag2 - 32'(qa_c) * 32'd45;

  always_ff @(posedge clk) begin
    qa3  <= qa_c;
    ra3  <= rem_c[5:0];
    neg3 <= neg2;
    // remainder part of the scaled quotient
    prod2 <= P2W'({ra3, {T{1'b0}}}) * P2W'(gte_pkg::DIV45_MUL_LO);
    qa4   <= qa3;
    neg4  <= neg3;
    q5    <= 32'((64'(qa4) << T) + 64'(prod2 >> gte_pkg::DIV45_SHIFT_LO));
    neg5  <= neg4;
    bam6  <= neg5 ? (32'd0 - q5) : q5;
  end

  // reduce to the nearest quadrant
  assign bias = bam6 + 32'h2000_0000;
  assign zr   = bam6 - {bias[31:30], 30'd0};

  always_ff @(posedge clk) begin
    quad7 <= bias[31:30];
    z7    <= 33'(signed'(zr));
  end

  for (genvar i = 0; i < ROT; i++) begin : g_rot
    logic signed [33:0] xi, yi;
    logic signed [32:0] zi;
    logic [1:0]         qi;
    logic signed [32:0] ang;
    if (i == 0) begin : g_first
      assign xi = gte_pkg::GAIN_Q30;
      assign yi = 34'sd0;
      assign zi = z7;
      assign qi = quad7;
    end else begin : g_next
      assign xi = cx[i];
      assign yi = cy[i];
      assign zi = cz[i];
      assign qi = cq[i];
    end
    assign ang = signed'(33'(gte_pkg::atan_bam(i)));
    always_ff @(posedge clk) begin
      if (zi >= 0) begin
        cx[i+1] <= xi - (yi >>> i);
        cy[i+1] <= yi + (xi >>> i);
        cz[i+1] <= zi - ang;
      end else begin
        cx[i+1] <= xi + (yi >>> i);
        cy[i+1] <= yi - (xi >>> i);
        cz[i+1] <= zi + ang;
      end
      cq[i+1] <= qi;
    end
  end

  always_ff @(posedge clk) begin
    case (cq[ROT])
      QUAD_0: begin
        cos_q <= 32'(cx[ROT]);
        sin_q <= 32'(cy[ROT]);
      end
      QUAD_1: begin
        cos_q <= 32'(-cy[ROT]);
        sin_q <= 32'(cx[ROT]);
      end
      QUAD_2: begin
        cos_q <= 32'(-cx[ROT]);
        sin_q <= 32'(-cy[ROT]);
      end
      default: begin
        cos_q <= 32'(cy[ROT]);
        sin_q <= 32'(-cx[ROT]);
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/gte_ecef.sv @@
// Geodetic point to earth-centred coordinates: sin/cos, Newton reciprocal root, products.
`default_nettype none
module gte_ecef #(
  parameter int ANGLE_FRAC_BITS = gte_pkg::ANGLE_FRAC_BITS,
  parameter int POS_FRAC_BITS   = gte_pkg::POS_FRAC_BITS,
  localparam int PW             = POS_FRAC_BITS + 25
) (
  input  wire logic               clk,
  input  wire logic signed [30:0] lat,
  input  wire logic signed [31:0] lon,
  input  wire logic signed [25:0] alt,
  output logic signed      [PW-1:0] pos_x,
  output logic signed      [PW-1:0] pos_y,
  output logic signed      [PW-1:0] pos_z,
  output gte_pkg::trig_t          trig
);

  logic signed [31:0] sl, cl, sn, cn;
  logic signed [31:0] ss, es, w, w49, w59, r1, r1d, rr2, t2, r2, r2d, rr3, t3, r3;
  logic signed [32:0] d2, d3, r2p, r3p;
  logic [54:0]        nprod;
  logic signed [PW-1:0] nr, nr70, p, mne, zz, pc;
  logic signed [25:0] alt67, alt70;
  logic signed [31:0] cl68, cn71, sn71, sl71;

  gte_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lat (
    .clk(clk), .angle(32'(lat)), .sin_q(sl), .cos_q(cl)
  );
  gte_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lon (
    .clk(clk), .angle(lon), .sin_q(sn), .cos_q(cn)
  );

  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_ss (.clk(clk), .a(sl), .b(sl), .p(ss));
  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_es (
    .clk(clk), .a(gte_pkg::E2_Q30), .b(ss), .p(es)
  );

  // first Newton step from 1.0 reduces to (3 - w) / 2
  always_ff @(posedge clk) begin
    w  <= 32'(gte_pkg::ONE_Q30 - 33'(es));
    r1 <= 32'((gte_pkg::THREE_Q30 - 33'(w)) >>> 1);
  end

  gte_delay #(.W(32), .D(4))  u_w49 (.clk(clk), .d(w), .q(w49));
  gte_delay #(.W(32), .D(14)) u_w59 (.clk(clk), .d(w), .q(w59));
  gte_delay #(.W(32), .D(7))  u_r1d (.clk(clk), .d(r1), .q(r1d));

  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_rr2 (.clk(clk), .a(r1), .b(r1), .p(rr2));
  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_t2 (.clk(clk), .a(w49), .b(rr2), .p(t2));

  always_ff @(posedge clk) begin
    d2 <= gte_pkg::THREE_Q30 - 33'(t2);
  end

  gte_mulq #(.AW(32), .BW(33), .OW(33)) u_r2 (.clk(clk), .a(r1d), .b(d2), .p(r2p));
  assign r2 = 32'(r2p >>> 1);

  gte_delay #(.W(32), .D(7)) u_r2d (.clk(clk), .d(r2), .q(r2d));

  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_rr3 (.clk(clk), .a(r2), .b(r2), .p(rr3));
  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_t3 (.clk(clk), .a(w59), .b(rr3), .p(t3));

  always_ff @(posedge clk) begin
    d3 <= gte_pkg::THREE_Q30 - 33'(t3);
  end

  gte_mulq #(.AW(32), .BW(33), .OW(33)) u_r3 (.clk(clk), .a(r2d), .b(d3), .p(r3p));
  assign r3 = 32'(r3p >>> 1);

  always_ff @(posedge clk) begin
    nprod <= 55'(gte_pkg::SEMI_MAJOR_M) * 55'(unsigned'(r3));
  end

  assign nr = signed'(PW'(nprod >> (gte_pkg::Q_BITS - POS_FRAC_BITS)));

  gte_delay #(.W(26), .D(67)) u_alt67 (.clk(clk), .d(alt), .q(alt67));
  gte_delay #(.W(26), .D(3))  u_alt70 (.clk(clk), .d(alt67), .q(alt70));
  gte_delay #(.W(PW), .D(3))  u_nr70  (.clk(clk), .d(nr), .q(nr70));

  always_ff @(posedge clk) begin
    p <= nr + PW'(alt67);
  end

  gte_mulq #(.AW(PW), .BW(32), .OW(PW)) u_mne (
    .clk(clk), .a(nr), .b(gte_pkg::E2_Q30), .p(mne)
  );

  always_ff @(posedge clk) begin
    zz <= nr70 - mne + PW'(alt70);
  end

  gte_delay #(.W(32), .D(30)) u_cl68 (.clk(clk), .d(cl), .q(cl68));
  gte_delay #(.W(32), .D(33)) u_cn71 (.clk(clk), .d(cn), .q(cn71));
  gte_delay #(.W(32), .D(33)) u_sn71 (.clk(clk), .d(sn), .q(sn71));
  gte_delay #(.W(32), .D(33)) u_sl71 (.clk(clk), .d(sl), .q(sl71));

  gte_mulq #(.AW(PW), .BW(32), .OW(PW)) u_pc (.clk(clk), .a(p), .b(cl68), .p(pc));
  gte_mulq #(.AW(PW), .BW(32), .OW(PW)) u_x (.clk(clk), .a(pc), .b(cn71), .p(pos_x));
  gte_mulq #(.AW(PW), .BW(32), .OW(PW)) u_y (.clk(clk), .a(pc), .b(sn71), .p(pos_y));
  gte_mulq #(.AW(PW), .BW(32), .OW(PW)) u_z (.clk(clk), .a(zz), .b(sl71), .p(pos_z));

  gte_delay #(.W(32), .D(3)) u_tsl (.clk(clk), .d(sl71), .q(trig.sin_lat));
  gte_delay #(.W(32), .D(6)) u_tcl (.clk(clk), .d(cl68), .q(trig.cos_lat));
  gte_delay #(.W(32), .D(3)) u_tsn (.clk(clk), .d(sn71), .q(trig.sin_lon));
  gte_delay #(.W(32), .D(3)) u_tcn (.clk(clk), .d(cn71), .q(trig.cos_lon));

endmodule
`default_nettype wire

@@ hdl/geodetic_to_local_enu.sv @@
// Top level: WGS84 geodetic target to local east/north/up about a configured reference.
//
//  channel   signals                                   handshake
//  request   start, target_lat/lon/alt                  accepted when start && !busy
//  result    done, east, north, up_offset, ref_ready    one-cycle strobe, no stall
//  config    cfg_valid, cfg_index, cfg_data             written when cfg_valid && cfg_ready
//
// One request per cycle. The delay from an accepted request to its result is set by the
// two ECEF units (38-stage sine/cosine front end, then the Newton reciprocal-root chain of
// 3-stage multipliers) and the 8-stage rotation.
// Reset clears the configuration registers and the valid line; payload is not reset.
// busy stays low and the pipeline never holds.
`default_nettype none
module geodetic_to_local_enu #(
  parameter int ANGLE_FRAC_BITS = gte_pkg::ANGLE_FRAC_BITS,
  parameter int POS_FRAC_BITS   = gte_pkg::POS_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [30:0] target_lat,
  input  wire logic signed [31:0] target_lon,
  input  wire logic signed [25:0] target_alt,
  output logic                    done,
  output logic signed      [32:0] east,
  output logic signed      [32:0] north,
  output logic signed      [32:0] up_offset,
  output logic                    ref_ready,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);

  localparam int PW      = POS_FRAC_BITS + 25;
  localparam int DW      = PW + 1;
  localparam int SW      = DW + 2;
  localparam int XW      = (SW > 34) ? SW : 34;
  localparam int OUT_LAT = gte_pkg::ECEF_LAT + 8;

  localparam logic signed [XW-1:0] SAT_HI = XW'(34'sh0FFFFFFFF);
  localparam logic signed [XW-1:0] SAT_LO = XW'(-34'sh100000000);

  logic signed [30:0] ref_lat;
  logic signed [31:0] ref_lon;
  logic signed [25:0] ref_alt;
  logic               ref_set;

  logic signed [30:0] in_lat;
  logic signed [31:0] in_lon;
  logic signed [25:0] in_alt;
  logic               in_vld;
  logic [OUT_LAT-1:0] vpipe;

  logic signed [PW-1:0] tx, ty, tz, rx, ry, rz;
  gte_pkg::trig_t       trig_t_unused, trig0, trig77;
  logic signed [DW-1:0] dx, dy, dz, dx77, dy77, dz77;
  logic signed [31:0]   scn, ssn, ccn, csn;
  logic signed [DW-1:0] a1, a2, b1, b2, b3, c1, c2, c3;
  logic signed [SW-1:0] e_s, n_s, u_s;

  function automatic logic signed [32:0] sat33(input logic signed [SW-1:0] v);
    logic signed [XW-1:0] x;
    x = XW'(v);
    if (x > SAT_HI) begin
      x = SAT_HI;
    end else if (x < SAT_LO) begin
      x = SAT_LO;
    end
    return 33'(x);
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_lat <= '0;
      ref_lon <= '0;
      ref_alt <= '0;
      ref_set <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gte_pkg::REG_REF_LAT: ref_lat <= cfg_data[30:0];
        gte_pkg::REG_REF_LON: ref_lon <= cfg_data;
        gte_pkg::REG_REF_ALT: ref_alt <= cfg_data[25:0];
        gte_pkg::REG_REF_SET: ref_set <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      vpipe  <= '0;
    end else begin
      in_vld <= start && !busy;
      vpipe  <= {vpipe[OUT_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_lat <= target_lat;
      in_lon <= target_lon;
      in_alt <= target_alt;
    end
  end

  gte_ecef #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_tgt (
    .clk(clk), .lat(in_lat), .lon(in_lon), .alt(in_alt),
    .pos_x(tx), .pos_y(ty), .pos_z(tz), .trig(trig_t_unused)
  );

  // the reference point runs alongside every request from the held registers
  gte_ecef #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_ref (
    .clk(clk), .lat(ref_lat), .lon(ref_lon), .alt(ref_alt),
    .pos_x(rx), .pos_y(ry), .pos_z(rz), .trig(trig0)
  );

  always_ff @(posedge clk) begin
    dx <= DW'(tx) - DW'(rx);
    dy <= DW'(ty) - DW'(ry);
    dz <= DW'(tz) - DW'(rz) + DW'(trig_t_unused.sin_lat) - DW'(trig_t_unused.sin_lat);
  end

  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_scn (
    .clk(clk), .a(trig0.sin_lat), .b(trig0.cos_lon), .p(scn));
  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_ssn (
    .clk(clk), .a(trig0.sin_lat), .b(trig0.sin_lon), .p(ssn));
  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_ccn (
    .clk(clk), .a(trig0.cos_lat), .b(trig0.cos_lon), .p(ccn));
  gte_mulq #(.AW(32), .BW(32), .OW(32)) u_csn (
    .clk(clk), .a(trig0.cos_lat), .b(trig0.sin_lon), .p(csn));

  gte_delay #(.W(DW), .D(2)) u_dx (.clk(clk), .d(dx), .q(dx77));
  gte_delay #(.W(DW), .D(2)) u_dy (.clk(clk), .d(dy), .q(dy77));
  gte_delay #(.W(DW), .D(2)) u_dz (.clk(clk), .d(dz), .q(dz77));
  gte_delay #(.W($bits(gte_pkg::trig_t)), .D(3)) u_trig (
    .clk(clk), .d(trig0), .q(trig77));

  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_a1 (
    .clk(clk), .a(dx77), .b(trig77.sin_lon), .p(a1));
  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_a2 (
    .clk(clk), .a(dy77), .b(trig77.cos_lon), .p(a2));
  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_b1 (.clk(clk), .a(dx77), .b(scn), .p(b1));
  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_b2 (.clk(clk), .a(dy77), .b(ssn), .p(b2));
  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_b3 (
    .clk(clk), .a(dz77), .b(trig77.cos_lat), .p(b3));
  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_c1 (.clk(clk), .a(dx77), .b(ccn), .p(c1));
  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_c2 (.clk(clk), .a(dy77), .b(csn), .p(c2));
  gte_mulq #(.AW(DW), .BW(32), .OW(DW)) u_c3 (
    .clk(clk), .a(dz77), .b(trig77.sin_lat), .p(c3));

  always_ff @(posedge clk) begin
    e_s <= SW'(a2) - SW'(a1);
    n_s <= SW'(b3) - SW'(b1) - SW'(b2);
    u_s <= SW'(c1) + SW'(c2) + SW'(c3);
  end

  // force zero while the reference-set flag is clear
  always_ff @(posedge clk) begin
    east      <= ref_set ? sat33(e_s) : 33'sd0;
    north     <= ref_set ? sat33(n_s) : 33'sd0;
    up_offset <= ref_set ? sat33(u_s) : 33'sd0;
    ref_ready <= ref_set;
  end

  assign done = vpipe[OUT_LAT-1];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(OUT_LAT+1) done)
    else $error("result strobe missing after accepted request");

  a_zero_unset: assert property (@(posedge clk) disable iff (rst)
    (done && !ref_ready) |-> (east == 33'sd0 && north == 33'sd0 && up_offset == 33'sd0))
    else $error("nonzero result without reference");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for geodetic_to_local_enu: random and directed requests checked against a local model.
`timescale 1ns / 100ps
`default_nettype none

class enu_scoreboard;
  typedef struct {
    logic signed [32:0] east;
    logic signed [32:0] north;
    logic signed [32:0] up_offset;
    logic               ref_ready;
  } enu_t;

  enu_t       enu_q[$];
  int         errors;
  bit  [30:0] ref_lat;
  bit  [31:0] ref_lon;
  bit  [25:0] ref_alt;
  bit         ref_set;
  longint     atan_tab[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  localparam longint ONE  = 64'sd1073741824;
  localparam longint E2   = 64'sd7188036;
  localparam longint GAIN = 64'sd652032874;
  localparam longint OMAX = (64'sd1 <<< 32) - 1;
  localparam longint OMIN = -(64'sd1 <<< 32);

  function new();
    errors = 0;
    ref_lat = '0; ref_lon = '0; ref_alt = '0; ref_set = 1'b0;
  endfunction

  task report(string what, logic signed [32:0] got, logic signed [32:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      gte_pkg::REG_REF_LAT: ref_lat = data[30:0];
      gte_pkg::REG_REF_LON: ref_lon = data;
      gte_pkg::REG_REF_ALT: ref_alt = data[25:0];
      gte_pkg::REG_REF_SET: ref_set = data[0];
      default: ;
    endcase
  endfunction

  // (a*b)>>30 truncated toward zero
  function longint qmul(longint a, longint b);
    logic [127:0] pa, pb, p;
    longint r;
    pa = (a < 0) ? 128'(-a) : 128'(a);
    pb = (b < 0) ? 128'(-b) : 128'(b);
    p = (pa * pb) >> 30;
    r = longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function void sin_cos(longint ang, output longint s, output longint c);
    longint     n, z, x, y, dx, dy;
    logic [31:0] bam, quad, rem;
    n = ang * 512;
    bam = 32'(n / 360);
    quad = ((bam + 32'h20000000) >> 30) & 32'd3;
    rem = bam - (quad << 30);
    z = longint'(signed'(rem));
    x = GAIN; y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (quad)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function void ecef(longint lat, longint lon, longint alt,
                     output longint x, output longint y, output longint z,
                     output longint sl, output longint cl,
                     output longint sn, output longint cn);
    longint      w, r, t, nr, p, pc;
    logic [63:0] prod;
    sin_cos(lat, sl, cl);
    sin_cos(lon, sn, cn);
    w = ONE - qmul(E2, qmul(sl, sl));
    r = ONE;
    for (int i = 0; i < 3; i++) begin
      t = qmul(w, qmul(r, r));
      r = qmul(r, 3 * ONE - t) >>> 1;
    end
    prod = 64'd6378137 * 64'(r);
    nr = longint'(prod >> 22);
    p = nr + alt;
    pc = qmul(p, cl);
    x = qmul(pc, cn);
    y = qmul(pc, sn);
    z = qmul(nr - qmul(nr, E2) + alt, sl);
  endfunction

  function logic signed [32:0] clip(longint v);
    if (v > OMAX) v = OMAX;
    if (v < OMIN) v = OMIN;
    return v[32:0];
  endfunction

  function void note_request(logic signed [30:0] lat, logic signed [31:0] lon,
                             logic signed [25:0] alt);
    enu_t   res;
    longint rx, ry, rz, tx, ty, tz, sl0, cl0, sn0, cn0, sl, cl, sn, cn;
    longint dx, dy, dz, e, n, u;
    if (!ref_set) begin
      res = '{33'sd0, 33'sd0, 33'sd0, 1'b0};
    end else begin
      ecef(longint'(signed'(ref_lat)), longint'(signed'(ref_lon)),
           longint'(signed'(ref_alt)), rx, ry, rz, sl0, cl0, sn0, cn0);
      ecef(longint'(lat), longint'(lon), longint'(alt), tx, ty, tz, sl, cl, sn, cn);
      dx = tx - rx; dy = ty - ry; dz = tz - rz;
      e = qmul(dx, -sn0) + qmul(dy, cn0);
      n = -qmul(dx, qmul(sl0, cn0)) - qmul(dy, qmul(sl0, sn0)) + qmul(dz, cl0);
      u = qmul(dx, qmul(cl0, cn0)) + qmul(dy, qmul(cl0, sn0)) + qmul(dz, sl0);
      res = '{clip(e), clip(n), clip(u), 1'b1};
    end
    enu_q.push_back(res);
  endfunction

  task check_result(logic signed [32:0] e, logic signed [32:0] n,
                    logic signed [32:0] u, logic rr);
    enu_t want;
    if (enu_q.size() == 0) begin
      report("unexpected result", e, 0);
    end else begin
      want = enu_q.pop_front();
      if (e !== want.east) report("east", e, want.east);
      if (n !== want.north) report("north", n, want.north);
      if (u !== want.up_offset) report("up_offset", u, want.up_offset);
      if (rr !== want.ref_ready) report("ref_ready", 33'(rr), 33'(want.ref_ready));
    end
  endtask
endclass

module tb;

  localparam int     DRAIN  = 100;
  localparam longint LIMIT  = 2000000;
  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;
  localparam longint ALT_MIN = -2560000;
  localparam longint ALT_MAX = 25600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [30:0] target_lat = '0;
  logic signed [31:0] target_lon = '0;
  logic signed [25:0] target_alt = '0;
  logic               done;
  logic signed [32:0] east, north, up_offset;
  logic               ref_ready;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [1:0]  cfg_index = '0;
  logic        [31:0] cfg_data = '0;

  enu_scoreboard sb = new();
  longint        cycles = 0;
  bit            no_idle;

  geodetic_to_local_enu DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .target_lat(target_lat), .target_lon(target_lon), .target_alt(target_alt),
    .done(done), .east(east), .north(north), .up_offset(up_offset),
    .ref_ready(ref_ready), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("geodetic_to_local_enu test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(east, north, up_offset, ref_ready);
  end

  function int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (no_idle || r < 60) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 20));
    return int'($urandom_range(50, 200));
  endfunction

  function longint in_range(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  task send(longint lat, longint lon, longint alt);
    int gap;
    start <= 1'b1;
    target_lat <= lat[30:0];
    target_lon <= lon[31:0];
    target_alt <= alt[25:0];
    do @(posedge clk); while (busy);
    sb.note_request(lat[30:0], lon[31:0], alt[25:0]);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_random();
    if ($urandom_range(0, 4) == 0)
      send(longint'($urandom()), longint'($urandom()), longint'($urandom()));
    else
      send(in_range(-LAT_MAX, LAT_MAX), in_range(-LON_MAX, LON_MAX),
           in_range(ALT_MIN, ALT_MAX));
  endtask

  // hold requests off until the pipeline has emptied
  task wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.enu_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task set_ref(longint lat, longint lon, longint alt, bit valid);
    write_reg(gte_pkg::REG_REF_LAT, lat[31:0]);
    write_reg(gte_pkg::REG_REF_LON, lon[31:0]);
    write_reg(gte_pkg::REG_REF_ALT, alt[31:0]);
    write_reg(gte_pkg::REG_REF_SET, {31'd0, valid});
  endtask

  task directed_items();
    send(0, 0, 0);
    send(LAT_MAX, 0, 0);
    send(-LAT_MAX, 0, 0);
    send(0, LON_MAX, 0);
    send(0, -LON_MAX, ALT_MAX);
    send(LAT_MAX, LON_MAX, ALT_MAX);
    send(-LAT_MAX, -LON_MAX, ALT_MIN);
    send(64'h3FFF_FFFF, 64'h7FFF_FFFF, 64'h01FF_FFFF);
    send(64'h4000_0000, 64'h8000_0000, 64'h0200_0000);
    send(LAT_MAX + 83886080, 3 * LON_MAX, 12345);
    send(longint'(sb.ref_lat), longint'(sb.ref_lon), longint'(sb.ref_alt));
    send(64'h7FFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
  endtask

  initial begin
    int n_phase;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reference never written: outputs forced to zero
    send(LAT_MAX, LON_MAX, ALT_MAX);
    send(-LAT_MAX, -LON_MAX, ALT_MIN);
    wait_idle();
    set_ref(in_range(-LAT_MAX, LAT_MAX), in_range(-LON_MAX, LON_MAX), ALT_MAX, 1'b0);
    send(0, 0, 0);
    send_random();
    wait_idle();

    write_reg(gte_pkg::REG_REF_SET, 32'd1);
    set_ref(0, 0, 0, 1'b1);
    directed_items();
    wait_idle();
    set_ref(LAT_MAX, LON_MAX, ALT_MAX, 1'b1);
    directed_items();
    wait_idle();
    set_ref(-LAT_MAX, -LON_MAX, ALT_MIN, 1'b1);
    send(LAT_MAX, LON_MAX, ALT_MAX);
    send(0, 0, 0);
    wait_idle();

    for (n_phase = 0; n_phase < 8; n_phase++) begin
      no_idle = (n_phase % 3 == 1);
      if ($urandom_range(0, 3) == 0)
        set_ref(longint'($urandom()), longint'($urandom()), longint'($urandom()),
                $urandom_range(0, 4) != 0);
      else
        set_ref(in_range(-LAT_MAX, LAT_MAX), in_range(-LON_MAX, LON_MAX),
                in_range(ALT_MIN, ALT_MAX), $urandom_range(0, 4) != 0);
      repeat (125) send_random();
      wait_idle();
    end

    if (sb.enu_q.size() != 0) sb.report("results missing", 33'(sb.enu_q.size()), 0);
    if (sb.errors == 0) begin
      $display("geodetic_to_local_enu test passed");
    end else begin
      $display("geodetic_to_local_enu test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
